FILE: rtl/lpnal_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpnal_pkg
// Types and constants shared by the length-prefixed to start-code converter.
// ----------------------------------------------------------------------------
package lpnal_pkg;

  localparam int unsigned DefQueueDepth = 4;
  localparam int unsigned LenFieldReset = 4;
  localparam int unsigned LenFieldMax   = 4;
  // start code 00 00 00 01 followed by the unit header byte
  localparam int unsigned StartCodeLen  = 4;
  localparam logic [7:0]  StartCodeLast = 8'h01;
  localparam logic [7:0]  StartCodeZero = 8'h00;

  typedef enum logic [1:0] {
    PH_PREFIX,
    PH_HEADER,
    PH_PAYLOAD,
    PH_DISCARD
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_ZERO_LEN,
    ST_TRUNC
  } status_e;

  typedef enum logic [1:0] {
    CMD_STATUS,
    CMD_HEADER,
    CMD_DATA
  } cmd_kind_e;

  // one queued command from the front end
  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] data;
    status_e    status;
    logic       last;
  } cmd_t;

  // effective length field size: 0 acts as 1, above the maximum acts as the maximum
  function automatic logic [2:0] field_len(input logic [2:0] cfg);
    logic [2:0] len;
    if (cfg == 3'd0) begin
      len = 3'd1;
    end else if (cfg > 3'(LenFieldMax)) begin
      len = 3'(LenFieldMax);
    end else begin
      len = cfg;
    end
    return len;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/lpnal_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpnal_front
// Parses the length prefixes and issues one command per byte that has output.
// ----------------------------------------------------------------------------
module lpnal_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic [2:0]    cfg_wdata_i,
  input  wire logic          accept_i,
  input  wire logic [7:0]    data_byte_i,
  input  wire logic          sample_last_i,
  output lpnal_pkg::cmd_t    cmd_o,
  output logic               cmd_valid_o
);
  import lpnal_pkg::*;

  logic [2:0]  len_cfg_q;
  phase_e      phase_q, phase_d;
  logic [2:0]  prefix_cnt_q, prefix_cnt_d;
  logic [31:0] accum_q, accum_d;
  logic [31:0] remain_q, remain_d;

  logic [2:0]  cnt_inc;
  logic [31:0] accum_new;
  logic        len_done;
  logic        len_zero;
  logic        remain_nz;
  logic [31:0] remain_pay;

  assign cnt_inc    = prefix_cnt_q + 3'd1;
  assign accum_new  = {accum_q[23:0], data_byte_i};
  assign len_done   = cnt_inc >= field_len(len_cfg_q);
  assign len_zero   = accum_new == 32'd0;
  assign remain_nz  = remain_q != 32'd0;
  assign remain_pay = remain_nz ? remain_q - 32'd1 : 32'd0;

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (accept_i) begin
      if (sample_last_i) begin
        phase_d = PH_PREFIX;
      end else begin
        unique case (phase_q)
          PH_PREFIX: begin
            if (len_done) phase_d = len_zero ? PH_DISCARD : PH_HEADER;
          end
          PH_HEADER:  phase_d = remain_nz ? PH_PAYLOAD : PH_PREFIX;
          PH_PAYLOAD: phase_d = (remain_pay == 32'd0) ? PH_PREFIX : PH_PAYLOAD;
          PH_DISCARD: phase_d = PH_DISCARD;
          default:    phase_d = PH_PREFIX;
        endcase
      end
    end
  end

  // datapath and command
  always_comb begin
    prefix_cnt_d = prefix_cnt_q;
    accum_d      = accum_q;
    remain_d     = remain_q;
    cmd_valid_o  = 1'b0;
    cmd_o.kind   = CMD_STATUS;
    cmd_o.data   = data_byte_i;
    cmd_o.status = ST_OK;
    cmd_o.last   = sample_last_i;
    if (accept_i) begin
      unique case (phase_q)
        PH_PREFIX: begin
          accum_d      = accum_new;
          prefix_cnt_d = cnt_inc;
          if (len_done) begin
            prefix_cnt_d = 3'd0;
            accum_d      = 32'd0;
            if (len_zero) begin
              cmd_valid_o  = 1'b1;
              cmd_o.status = ST_ZERO_LEN;
            end else begin
              remain_d = accum_new - 32'd1;
              if (sample_last_i) begin
                cmd_valid_o  = 1'b1;
                cmd_o.status = ST_TRUNC;
              end
            end
          end else if (sample_last_i) begin
            cmd_valid_o  = 1'b1;
            cmd_o.status = ST_TRUNC;
          end
        end
        PH_HEADER: begin
          cmd_valid_o  = 1'b1;
          cmd_o.kind   = CMD_HEADER;
          cmd_o.status = (sample_last_i && remain_nz) ? ST_TRUNC : ST_OK;
        end
        PH_PAYLOAD: begin
          remain_d     = remain_pay;
          cmd_valid_o  = 1'b1;
          cmd_o.kind   = CMD_DATA;
          cmd_o.status = (sample_last_i && remain_pay != 32'd0) ? ST_TRUNC : ST_OK;
        end
        PH_DISCARD: begin
          if (sample_last_i) begin
            cmd_valid_o  = 1'b1;
            cmd_o.status = ST_ZERO_LEN;
          end
        end
        default: begin
          cmd_valid_o = 1'b0;
        end
      endcase
      if (sample_last_i) begin
        prefix_cnt_d = 3'd0;
        accum_d      = 32'd0;
        remain_d     = 32'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_cfg_q    <= 3'(LenFieldReset);
      phase_q      <= PH_PREFIX;
      prefix_cnt_q <= 3'd0;
      accum_q      <= 32'd0;
      remain_q     <= 32'd0;
    end else begin
      if (cfg_we_i) len_cfg_q <= cfg_wdata_i;
      phase_q      <= phase_d;
      prefix_cnt_q <= prefix_cnt_d;
      accum_q      <= accum_d;
      remain_q     <= remain_d;
    end
  end

`ifndef SYNTHESIS
  // a full prefix always resets the count, so it never holds the maximum
  a_prefix_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prefix_cnt_q < 3'(LenFieldMax))
    else $error("prefix count out of range");

  a_payload_remain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAYLOAD |-> remain_q != 32'd0)
    else $error("payload phase with nothing left");

  a_sample_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && sample_last_i |=> phase_q == PH_PREFIX && prefix_cnt_q == 3'd0
      && accum_q == 32'd0)
    else $error("state not cleared at end of sample");
`endif

endmodule
`default_nettype wire

FILE: rtl/lpnal_cmdq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpnal_cmdq
// Small command queue between the parser and the output sequencer.
// ----------------------------------------------------------------------------
module lpnal_cmdq #(
  parameter int unsigned Depth = lpnal_pkg::DefQueueDepth
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            wr_en_i,
  input  wire lpnal_pkg::cmd_t wr_data_i,
  output logic                 full_o,
  input  wire logic            rd_en_i,
  output lpnal_pkg::cmd_t      rd_data_o,
  output logic                 empty_o
);
  import lpnal_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_wr, do_rd;

  assign full_o    = count_q == CntW'(Depth);
  assign empty_o   = count_q == '0;
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wr_ptr_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) wr_ptr_q <= ptr_next(wr_ptr_q);
      if (do_rd) rd_ptr_q <= ptr_next(rd_ptr_q);
      if (do_wr && !do_rd) begin
        count_q <= count_q + CntW'(1);
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count overflow");

  a_no_lost_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_i && !rd_en_i |-> !full_o)
    else $error("write into full queue");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_wr && !do_rd |=> count_q == $past(count_q) + CntW'(1))
    else $error("queue count not advanced");
`endif

endmodule
`default_nettype wire

FILE: rtl/lpnal_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpnal_back
// Expands queued commands into result words; a unit header becomes the start
// code plus the header byte. Results sit in an output register.
// ----------------------------------------------------------------------------
module lpnal_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire lpnal_pkg::cmd_t cmd_i,
  input  wire logic            cmd_valid_i,
  output logic                 cmd_pop_o,
  output logic                 empty,
  input  wire logic            pop,
  output logic [7:0]           out_byte_o,
  output logic                 byte_valid_o,
  output logic                 run_last_o,
  output logic                 end_of_sample_o,
  output logic [1:0]           status_o
);
  import lpnal_pkg::*;

  logic [2:0] burst_q, burst_d;
  logic       out_valid_q;
  logic       load;
  logic       is_final;

  logic [7:0] res_byte;
  logic       res_valid;
  logic       res_run_last;
  logic       res_eos;
  status_e    res_status;

  assign load = cmd_valid_i && (!out_valid_q || pop);

  always_comb begin
    is_final     = 1'b1;
    res_byte     = 8'h00;
    res_valid    = 1'b0;
    res_status   = cmd_i.status;
    unique case (cmd_i.kind)
      CMD_HEADER: begin
        res_valid = 1'b1;
        if (burst_q < 3'(StartCodeLen)) begin
          is_final   = 1'b0;
          res_status = ST_OK;
          res_byte   = (burst_q == 3'(StartCodeLen - 1)) ? StartCodeLast : StartCodeZero;
        end else begin
          res_byte = cmd_i.data;
        end
      end
      CMD_DATA: begin
        res_valid = 1'b1;
        res_byte  = cmd_i.data;
      end
      CMD_STATUS: begin
        res_valid = 1'b0;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
    res_run_last = is_final;
    res_eos      = is_final && cmd_i.last;
  end

  assign cmd_pop_o = load && is_final;

  always_comb begin
    burst_d = burst_q;
    if (load) burst_d = is_final ? 3'd0 : burst_q + 3'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      burst_q     <= 3'd0;
    end else begin
      burst_q <= burst_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_o      <= res_byte;
      byte_valid_o    <= res_valid;
      run_last_o      <= res_run_last;
      end_of_sample_o <= res_eos;
      status_o        <= res_status;
    end
  end

  assign empty = !out_valid_q;

`ifndef SYNTHESIS
  a_burst_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    burst_q <= 3'(StartCodeLen))
    else $error("start code counter out of range");

  // mid-burst the header command must still be at the queue head
  a_burst_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    burst_q != 3'd0 |-> cmd_valid_i && cmd_i.kind == CMD_HEADER)
    else $error("start code burst without header command");

  a_word_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_q) |-> $past(pop))
    else $error("result word dropped without pop");
`endif

endmodule
`default_nettype wire

FILE: rtl/length_prefixed_nal_to_start_code.sv
`default_nettype none
// ----------------------------------------------------------------------------
// length_prefixed_nal_to_start_code
// Converts length-prefixed NAL units to start-code framing, one byte a word.
//
//   Channel | Handshake      | Payload
//   input   | push / full    | data_byte_i, sample_last_i
//   result  | empty / pop    | out_byte_o, byte_valid_o, run_last_o,
//           |                | end_of_sample_o, status_o
//   config  | cfg_we_i       | cfg_wdata_i (length field bytes)
//
// One input byte a cycle while full is low; each payload byte passes through
// the command queue into the output register. A unit header yields five
// result words from the output sequencer, so each unit adds four extra words
// on the result side; the command queue (QueueDepth entries) absorbs that
// until full rises. Reset clears the control state; the length field size
// resets to four bytes. Either side may stall at any time without loss.
// ----------------------------------------------------------------------------
module length_prefixed_nal_to_start_code #(
  parameter int unsigned QueueDepth = lpnal_pkg::DefQueueDepth
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [2:0] cfg_wdata_i,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       sample_last_i,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_byte_o,
  output logic            byte_valid_o,
  output logic            run_last_o,
  output logic            end_of_sample_o,
  output logic [1:0]      status_o
);
  import lpnal_pkg::*;

  cmd_t cmd_in, cmd_head;
  logic cmd_wr, q_empty, cmd_pop;
  logic accept;

  assign accept = push && !full;

  lpnal_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .accept_i      (accept),
    .data_byte_i   (data_byte_i),
    .sample_last_i (sample_last_i),
    .cmd_o         (cmd_in),
    .cmd_valid_o   (cmd_wr)
  );

  lpnal_cmdq #(
    .Depth (QueueDepth)
  ) u_cmdq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cmd_wr),
    .wr_data_i (cmd_in),
    .full_o    (full),
    .rd_en_i   (cmd_pop),
    .rd_data_o (cmd_head),
    .empty_o   (q_empty)
  );

  lpnal_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd_head),
    .cmd_valid_i     (!q_empty),
    .cmd_pop_o       (cmd_pop),
    .empty           (empty),
    .pop             (pop),
    .out_byte_o      (out_byte_o),
    .byte_valid_o    (byte_valid_o),
    .run_last_o      (run_last_o),
    .end_of_sample_o (end_of_sample_o),
    .status_o        (status_o)
  );

endmodule
`default_nettype wire

FILE: dv/length_prefixed_nal_to_start_code_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// length_prefixed_nal_to_start_code_tb
// Drives length-prefixed samples through the converter, one byte a word. A
// behavioural predictor queues the start-code framed words each accepted byte
// should produce, and every popped result word is checked field by field.
// The directed tests cover the register reset value, zero length units,
// truncation and a register change between units. Random streams follow
// across every length field setting, with random stalls on both sides.
// ----------------------------------------------------------------------------
module length_prefixed_nal_to_start_code_tb;
  import lpnal_pkg::*;

  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned PhaseBytes    = 20;
  localparam int unsigned NumPhases     = 10;
  localparam longint unsigned AllBytes  = 64'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       end_of_sample;
    status_e    status;
  } framed_word_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [2:0] cfg_wdata_i;
  logic       push;
  logic       full;
  logic [7:0] data_byte_i;
  logic       sample_last_i;
  logic       empty;
  logic       pop;
  logic [7:0] out_byte_o;
  logic       byte_valid_o;
  logic       run_last_o;
  logic       end_of_sample_o;
  logic [1:0] status_o;

  // predictor state
  logic [2:0]  len_cfg   = 3'(LenFieldReset);
  phase_e      conv_phase = PH_PREFIX;
  logic [2:0]  pfx_cnt   = '0;
  logic [31:0] len_acc   = '0;
  logic [31:0] remaining = '0;

  framed_word_t expected_words[$];
  logic [7:0]   sample_bytes[$];

  bit          idling_on = 1'b1;
  int unsigned pop_hold;
  int unsigned quiet_cycles;
  int unsigned err_count;
  int unsigned bytes_sent;
  int unsigned samples_sent;
  int unsigned words_checked;
  int unsigned zero_len_words;
  int unsigned trunc_words;
  int unsigned cfg_writes;

  length_prefixed_nal_to_start_code i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .push           (push),
    .full           (full),
    .data_byte_i    (data_byte_i),
    .sample_last_i  (sample_last_i),
    .empty          (empty),
    .pop            (pop),
    .out_byte_o     (out_byte_o),
    .byte_valid_o   (byte_valid_o),
    .run_last_o     (run_last_o),
    .end_of_sample_o(end_of_sample_o),
    .status_o       (status_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // 0 behaves as 1, anything above 4 as 4
  function automatic int unsigned field_bytes_for(input logic [2:0] setting);
    if (setting == 3'd0) begin
      return 1;
    end else if (setting > 3'd4) begin
      return 4;
    end
    return int'(setting);
  endfunction

  function automatic framed_word_t make_word(input logic [7:0] b, input logic v,
                                             input status_e st);
    framed_word_t w;
    w.out_byte      = b;
    w.byte_valid    = v;
    w.run_last      = 1'b0;
    w.end_of_sample = 1'b0;
    w.status        = st;
    return w;
  endfunction

  // queue the words that one accepted input byte should produce
  function automatic void predict_conversion(input logic [7:0] d, input logic l);
    framed_word_t words[$];
    framed_word_t w;
    bit           mark_trunc;
    mark_trunc = 1'b0;
    case (conv_phase)
      PH_PREFIX: begin
        len_acc = {len_acc[23:0], d};
        pfx_cnt = pfx_cnt + 3'd1;
        if (int'(pfx_cnt) >= field_bytes_for(len_cfg)) begin
          if (len_acc == '0) begin
            words.push_back(make_word(8'h00, 1'b0, ST_ZERO_LEN));
            conv_phase = PH_DISCARD;
          end else begin
            remaining  = len_acc - 32'd1;
            conv_phase = PH_HEADER;
            if (l) words.push_back(make_word(8'h00, 1'b0, ST_TRUNC));
          end
          pfx_cnt = '0;
          len_acc = '0;
        end else if (l) begin
          words.push_back(make_word(8'h00, 1'b0, ST_TRUNC));
        end
      end
      PH_HEADER: begin
        repeat (StartCodeLen - 1) words.push_back(make_word(StartCodeZero, 1'b1, ST_OK));
        words.push_back(make_word(StartCodeLast, 1'b1, ST_OK));
        words.push_back(make_word(d, 1'b1, ST_OK));
        conv_phase = (remaining != '0) ? PH_PAYLOAD : PH_PREFIX;
        mark_trunc = l && (remaining != '0);
      end
      PH_PAYLOAD: begin
        words.push_back(make_word(d, 1'b1, ST_OK));
        if (remaining != '0) remaining = remaining - 32'd1;
        if (remaining == '0) conv_phase = PH_PREFIX;
        mark_trunc = l && (remaining != '0);
      end
      default: begin
        if (l) words.push_back(make_word(8'h00, 1'b0, ST_ZERO_LEN));
      end
    endcase
    if (words.size() > 0) begin
      w = words.pop_back();
      w.run_last = 1'b1;
      if (l) w.end_of_sample = 1'b1;
      if (mark_trunc) w.status = ST_TRUNC;
      words.push_back(w);
    end
    foreach (words[i]) expected_words.push_back(words[i]);
    if (l) begin
      conv_phase = PH_PREFIX;
      pfx_cnt    = '0;
      len_acc    = '0;
      remaining  = '0;
    end
  endfunction

  function automatic void check_result_word();
    framed_word_t exp_w;
    if (expected_words.size() == 0) begin
      $error("result word with nothing expected: out_byte %02h status %0d",
             out_byte_o, status_o);
      err_count++;
      return;
    end
    exp_w = expected_words.pop_front();
    words_checked++;
    if (exp_w.status == ST_ZERO_LEN) zero_len_words++;
    if (exp_w.status == ST_TRUNC) trunc_words++;
    if (out_byte_o !== exp_w.out_byte) begin
      $error("out_byte: expected %02h, got %02h", exp_w.out_byte, out_byte_o);
      err_count++;
    end
    if (byte_valid_o !== exp_w.byte_valid) begin
      $error("byte_valid: expected %0b, got %0b", exp_w.byte_valid, byte_valid_o);
      err_count++;
    end
    if (run_last_o !== exp_w.run_last) begin
      $error("run_last: expected %0b, got %0b", exp_w.run_last, run_last_o);
      err_count++;
    end
    if (end_of_sample_o !== exp_w.end_of_sample) begin
      $error("end_of_sample: expected %0b, got %0b", exp_w.end_of_sample,
             end_of_sample_o);
      err_count++;
    end
    if (status_o !== exp_w.status) begin
      $error("status: expected %0d, got %0d", exp_w.status, status_o);
      err_count++;
    end
  endfunction

  // result side: check each popped word, then decide pop for the next edge
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) check_result_word();
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (pop_hold > 0) begin
      pop_hold--;
      pop <= 1'b0;
    end else if (idling_on && $urandom_range(0, 5) == 0) begin
      pop_hold = $urandom_range(0, 3);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("timeout: no handshake for %0d cycles", quiet_cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] d, input logic l);
    int unsigned gap;
    if (idling_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 4);
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push          <= 1'b1;
    data_byte_i   <= d;
    sample_last_i <= l;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    bytes_sent++;
    if (l) samples_sent++;
    predict_conversion(d, l);
  endtask

  // let every expected word arrive, then allow for words still in flight
  task automatic drain_results();
    push <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_len_field(input logic [2:0] setting);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= setting;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    len_cfg = setting;
    cfg_writes++;
  endtask

  // length field, header and payload of one unit, cut after keep bytes
  function automatic void add_unit(input logic [31:0] len, input longint unsigned keep);
    int unsigned     fl;
    longint unsigned total;
    fl    = field_bytes_for(len_cfg);
    total = longint'(fl) + longint'(len);
    if (keep < total) total = keep;
    for (longint unsigned i = 0; i < total; i++) begin
      if (i < fl) begin
        sample_bytes.push_back(8'(len >> (8 * (fl - 1 - int'(i)))));
      end else begin
        sample_bytes.push_back(8'($urandom));
      end
    end
  endfunction

  task automatic send_sample();
    foreach (sample_bytes[i]) send_byte(sample_bytes[i], i == sample_bytes.size() - 1);
    sample_bytes.delete();
  endtask

  function automatic logic [31:0] pick_len();
    if ($urandom_range(0, 7) == 0) return 32'($urandom_range(9, 40));
    return 32'($urandom_range(1, 8));
  endfunction

  task automatic random_sample();
    int unsigned fl;
    int unsigned kind;
    int unsigned keep_max;
    logic [31:0] len;
    fl   = field_bytes_for(len_cfg);
    kind = $urandom_range(0, 9);
    if (kind < 6) begin
      repeat ($urandom_range(1, 3)) add_unit(pick_len(), AllBytes);
    end else if (kind < 8) begin
      repeat ($urandom_range(0, 2)) add_unit(pick_len(), AllBytes);
      add_unit('0, AllBytes);
      repeat ($urandom_range(0, 4)) sample_bytes.push_back(8'($urandom));
    end else if (kind == 8) begin
      repeat ($urandom_range(0, 2)) add_unit(pick_len(), AllBytes);
      len = $urandom_range(0, 1) ? 32'($urandom_range(2, 12)) : 32'($urandom);
      if (fl < 4) len = len & ((32'd1 << (8 * fl)) - 32'd1);
      if (len == '0) len = 32'd1;
      keep_max = fl + ((len > 32'd12) ? 12 : int'(len) - 1);
      add_unit(len, $urandom_range(1, keep_max));
    end else begin
      repeat ($urandom_range(1, 10)) sample_bytes.push_back(8'($urandom));
    end
    send_sample();
  endtask

  task automatic test_default_field();
    // reset value: four length bytes
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  task automatic test_zero_length();
    drain_results();
    write_len_field(3'd1);
    // rest of the sample is dropped until its last byte
    send_byte(8'h00, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'hFF, 1'b1);
    drain_results();
    write_len_field(3'd2);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  task automatic test_truncation();
    drain_results();
    write_len_field(3'd1);
    send_byte(8'h07, 1'b1);
    send_byte(8'h03, 1'b0);
    send_byte(8'h80, 1'b1);
    send_byte(8'h04, 1'b0);
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b1);
    drain_results();
    write_len_field(3'd3);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  task automatic test_field_change_mid_sample();
    drain_results();
    write_len_field(3'd1);
    send_byte(8'h01, 1'b0);
    send_byte(8'h3C, 1'b0);
    drain_results();
    write_len_field(3'd2);
    send_byte(8'h00, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'hC3, 1'b1);
  endtask

  task automatic test_random_streams();
    logic [2:0]  order[8] = '{3'd4, 3'd1, 3'd0, 3'd2, 3'd3, 3'd5, 3'd6, 3'd7};
    logic [2:0]  setting;
    int unsigned start;
    for (int p = 0; p < NumPhases; p++) begin
      setting = (p < 8) ? order[p] : 3'($urandom_range(1, 4));
      drain_results();
      // final stretch runs with no stalls on either side
      if (p == NumPhases - 1) idling_on = 1'b0;
      write_len_field(setting);
      start = bytes_sent;
      while (bytes_sent - start < PhaseBytes) random_sample();
    end
  endtask

  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    push          <= 1'b0;
    data_byte_i   <= '0;
    sample_last_i <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_field();
    test_zero_length();
    test_truncation();
    test_field_change_mid_sample();
    test_random_streams();
    drain_results();

    $display("%0d samples, %0d bytes in, %0d words out, %0d register writes",
             samples_sent, bytes_sent, words_checked, cfg_writes);
    $display("status words seen: %0d zero length, %0d truncated",
             zero_len_words, trunc_words);
    if (err_count == 0 && expected_words.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
